@@ rtl/bswlo_pkg.sv @@
package bswlo_pkg;

    typedef enum logic [3:0] {
        REQ_PUSH    = 4'd0,
        REQ_POP     = 4'd1,
        REQ_TOP     = 4'd2,
        REQ_SORT    = 4'd3,
        REQ_REVERSE = 4'd4,
        REQ_MAX     = 4'd5,
        REQ_MIN     = 4'd6,
        REQ_AVG     = 4'd7,
        REQ_RMLARGE = 4'd8,
        REQ_DEDUPE  = 4'd9
    } req_e;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [3:0]         req_type;
        logic signed [31:0] push_value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         status;
        logic [3:0]         entry_count;
        logic               is_empty;
        logic               is_full;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_OP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DIV,
        S_DONE
    } state_e;

    // divider control and status
    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

@@ rtl/bswlo_div.sv @@
module bswlo_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bswlo_pkg::div_ctl_t   ctl,
    input  logic signed [38:0]    dividend,
    input  logic [6:0]            divisor,
    output bswlo_pkg::div_sts_t   sts,
    output logic signed [31:0]    quotient
);
    import bswlo_pkg::*;

    logic [38:0] rem_reg, rem_next;
    logic [38:0] quo_reg, quo_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [6:0]  dvs_reg, dvs_next;
    logic [39:0] trial;
    logic [38:0] mag;
    logic [38:0] qs;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        dvs_next  = dvs_reg;
        mag       = dividend[38] ? 39'(-dividend) : 39'(dividend);
        trial     = {rem_reg, quo_reg[38]} - {33'd0, dvs_reg};
        if (ctl.start)
        begin
            rem_next  = '0;
            quo_next  = mag;
            cnt_next  = 6'd39;
            neg_next  = dividend[38];
            dvs_next  = divisor;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[39])
            begin
                rem_next = trial[38:0];
                quo_next = {quo_reg[37:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[37:0], quo_reg[38]};
                quo_next = {quo_reg[37:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
        dvs_reg <= dvs_next;
    end

    assign qs       = neg_reg ? 39'(-quo_reg) : quo_reg;
    assign quotient = qs[31:0];
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
endmodule

@@ rtl/bounded_stack_with_list_ops_core.sv @@
// push, pop, empty stack and unused codes are answered straight from idle; top reads
// the top element first; the list operations walk the elements through the read, compare
// and shift states, and average sums them and then waits on the restoring divider;
// one request in flight, ready only when idle with no word waiting
// result register holds the answer until taken; reset clears count and control
// element memory is not cleared at reset
module bounded_stack_with_list_ops_core #(
    parameter int STACK_DEPTH = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bswlo_pkg::req_t   in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bswlo_pkg::rsp_t   out_data
);
    import bswlo_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // element storage, single write port, registered read
    logic signed [31:0] mem [STACK_DEPTH];
    logic               we;
    logic [AW-1:0]      waddr, raddr;
    logic signed [31:0] wdata, rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    state_e state_reg, state_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] i_reg, i_next;      // outer index
    logic [CW-1:0] j_reg, j_next;      // inner index
    logic [CW-1:0] k_reg, k_next;      // kept count / best index
    logic [3:0]    op_reg, op_next;
    logic signed [31:0] a_reg, a_next; // held operand
    logic signed [38:0] sum_reg, sum_next;
    logic          flag_reg, flag_next;
    logic          ov_reg, ov_next;
    rsp_t          rsp_reg, rsp_next;
    div_ctl_t      dctl;
    div_sts_t      dsts;
    logic signed [31:0] quo;

    bswlo_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (dctl),
        .dividend (sum_reg),
        .divisor  (7'(n_reg)),
        .sts      (dsts),
        .quotient (quo)
    );

    // less-than comparator shared by sort and min; max and remove largest compare separately
    logic lt;
    assign lt = rdata_reg < a_reg;

    function automatic rsp_t mk(input logic signed [31:0] v, input logic [1:0] s,
                                input logic [CW-1:0] n);
        rsp_t r;
        r.result_value = v;
        r.status       = s;
        r.entry_count  = 4'(n);
        r.is_empty     = (n == '0);
        r.is_full      = (n == CW'(STACK_DEPTH));
        return r;
    endfunction

    assign in_ready  = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        n_next = n_reg; i_next = i_reg; j_next = j_reg; k_next = k_reg;
        op_next = op_reg; a_next = a_reg; sum_next = sum_reg;
        flag_next = flag_reg; rsp_next = rsp_reg; ov_next = ov_reg;
        we = 1'b0; waddr = '0; wdata = a_reg; raddr = '0;
        dctl.start = 1'b0;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    op_next = in_data.req_type;
                    if (in_data.req_type == REQ_PUSH)
                    begin
                        if (n_reg == CW'(STACK_DEPTH))
                            rsp_next = mk('0, ST_FULL, n_reg);
                        else
                        begin
                            we = 1'b1; waddr = AW'(n_reg); wdata = in_data.push_value;
                            n_next = n_reg + 1'b1;
                            rsp_next = mk('0, ST_OK, n_reg + 1'b1);
                        end
                        ov_next = 1'b1;
                    end
                    else if (in_data.req_type > 4'd9)
                    begin
                        rsp_next = mk('0, ST_OK, n_reg);
                        ov_next = 1'b1;
                    end
                    else if (n_reg == '0)
                    begin
                        rsp_next = mk('0, ST_EMPTY, n_reg);
                        ov_next = 1'b1;
                    end
                    else if (in_data.req_type == REQ_POP)
                    begin
                        n_next = n_reg - 1'b1;
                        rsp_next = mk('0, ST_OK, n_reg - 1'b1);
                        ov_next = 1'b1;
                    end
                    else
                    begin
                        // first read: element 0 (top for top request)
                        i_next = '0; j_next = '0; k_next = '0;
                        sum_next = '0; flag_next = 1'b0;
                        if (in_data.req_type == REQ_TOP)
                            raddr = AW'(n_reg - 1'b1);
                        else if (in_data.req_type == REQ_REVERSE)
                            i_next = '0;
                        state_next = (in_data.req_type == REQ_TOP) ? S_DONE : S_RD_A;
                        if (in_data.req_type == REQ_DEDUPE)
                        begin
                            k_next = CW'(1);   // element 0 always kept
                            i_next = CW'(1);
                        end
                    end
                end
            end
            // read element i (into a_reg, or into the sum for average), then walk j
            S_RD_A:
            begin
                raddr = AW'(i_reg);
                state_next = S_RD_B;
                unique case (op_reg)
                    REQ_SORT:    j_next = i_reg + 1'b1;
                    REQ_REVERSE: j_next = n_reg - 1'b1 - i_reg;
                    REQ_DEDUPE:  j_next = '0;
                    default:     j_next = CW'(1);
                endcase
                if (op_reg == REQ_SORT && i_reg + 1'b1 >= n_reg)
                    state_next = S_DONE;
                if (op_reg == REQ_REVERSE && i_reg >= (n_reg >> 1))
                    state_next = S_DONE;
                if (op_reg == REQ_DEDUPE && i_reg >= n_reg)
                    state_next = S_DONE;
                if (op_reg == REQ_AVG && i_reg >= n_reg)
                begin
                    dctl.start = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_RD_B:
            begin
                // rdata_reg holds element i
                unique case (op_reg)
                    REQ_AVG:
                    begin
                        sum_next = sum_reg + 39'(rdata_reg);
                        i_next = i_reg + 1'b1;
                        state_next = S_RD_A;
                    end
                    REQ_MAX, REQ_MIN, REQ_RMLARGE:
                    begin
                        a_next = rdata_reg; k_next = '0;
                        raddr = AW'(j_reg);
                        // single element: remove largest still drops element 0
                        if (n_reg == CW'(1))
                            state_next = (op_reg == REQ_RMLARGE) ? S_SHIFT_RD : S_DONE;
                        else
                            state_next = S_OP;
                    end
                    default:
                    begin
                        a_next = rdata_reg;
                        raddr = AW'(j_reg);
                        flag_next = 1'b0;
                        state_next = S_OP;
                        if (op_reg == REQ_DEDUPE && k_reg == '0)
                            state_next = S_OP;
                    end
                endcase
            end
            S_OP:
            begin
                // rdata_reg holds element j
                unique case (op_reg)
                    REQ_SORT:
                    begin
                        if (lt)
                        begin
                            // keep element j on the read port for the swap
                            we = 1'b1; waddr = AW'(i_reg); wdata = rdata_reg;
                            raddr = AW'(j_reg);
                            state_next = S_SHIFT_WR;
                        end
                        else if (j_reg + 1'b1 >= n_reg)
                        begin
                            i_next = i_reg + 1'b1;
                            state_next = S_RD_A;
                        end
                        else
                        begin
                            j_next = j_reg + 1'b1;
                            raddr = AW'(j_reg + 1'b1);
                        end
                    end
                    REQ_REVERSE:
                    begin
                        we = 1'b1; waddr = AW'(i_reg); wdata = rdata_reg;
                        state_next = S_SHIFT_WR;
                    end
                    REQ_MAX, REQ_RMLARGE, REQ_MIN:
                    begin
                        if (op_reg == REQ_MIN ? lt : (a_reg < rdata_reg))
                        begin
                            a_next = rdata_reg; k_next = j_reg;
                        end
                        if (j_reg + 1'b1 >= n_reg)
                        begin
                            if (op_reg == REQ_RMLARGE)
                            begin
                                i_next = (op_reg == REQ_MIN ? lt : (a_reg < rdata_reg))
                                         ? j_reg : k_reg;
                                state_next = S_SHIFT_RD;
                            end
                            else
                                state_next = S_DONE;
                        end
                        else
                        begin
                            j_next = j_reg + 1'b1;
                            raddr = AW'(j_reg + 1'b1);
                        end
                    end
                    default: // dedupe: compare element i with kept j
                    begin
                        if (j_reg >= k_reg)
                        begin
                            if (!flag_reg)
                            begin
                                we = 1'b1; waddr = AW'(k_reg); wdata = a_reg;
                                k_next = k_reg + 1'b1;
                            end
                            i_next = i_reg + 1'b1;
                            state_next = S_RD_A;
                        end
                        else
                        begin
                            if (rdata_reg == a_reg)
                                flag_next = 1'b1;
                            j_next = j_reg + 1'b1;
                            raddr = AW'(j_reg + 1'b1);
                            state_next = S_SHIFT_RD;
                        end
                    end
                endcase
            end
            S_SHIFT_RD:
            begin
                if (op_reg == REQ_DEDUPE)
                begin
                    // bubble state: re-read element j so rdata_reg holds it back in S_OP
                    raddr = AW'(j_reg);
                    state_next = S_OP;
                end
                else
                begin
                    // remove largest: move i+1 down to i
                    if (i_reg + 1'b1 >= n_reg)
                    begin
                        n_next = n_reg - 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        raddr = AW'(i_reg + 1'b1);
                        state_next = S_SHIFT_WR;
                    end
                end
            end
            S_SHIFT_WR:
            begin
                unique case (op_reg)
                    REQ_RMLARGE:
                    begin
                        we = 1'b1; waddr = AW'(i_reg); wdata = rdata_reg;
                        i_next = i_reg + 1'b1;
                        state_next = S_SHIFT_RD;
                    end
                    REQ_REVERSE:
                    begin
                        we = 1'b1; waddr = AW'(j_reg); wdata = a_reg;
                        i_next = i_reg + 1'b1;
                        state_next = S_RD_A;
                    end
                    default: // sort: finish swap, continue with new a
                    begin
                        we = 1'b1; waddr = AW'(j_reg); wdata = a_reg;
                        a_next = rdata_reg;
                        if (j_reg + 1'b1 >= n_reg)
                        begin
                            i_next = i_reg + 1'b1;
                            state_next = S_RD_A;
                        end
                        else
                        begin
                            j_next = j_reg + 1'b1;
                            raddr = AW'(j_reg + 1'b1);
                            state_next = S_OP;
                        end
                    end
                endcase
            end
            S_DIV:
            begin
                if (dsts.done)
                begin
                    a_next = quo;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                unique case (op_reg)
                    REQ_TOP:
                        rsp_next = mk(rdata_reg, ST_OK, n_reg);
                    REQ_MAX, REQ_MIN, REQ_AVG, REQ_RMLARGE:
                        rsp_next = mk(a_reg, ST_OK, n_reg);
                    REQ_DEDUPE:
                    begin
                        rsp_next = mk('0, ST_OK, k_reg);
                        n_next = k_reg;
                    end
                    default:
                        rsp_next = mk('0, ST_OK, n_reg);
                endcase
                ov_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next; j_reg <= j_next; k_reg <= k_next; op_reg <= op_next;
        a_reg <= a_next; sum_reg <= sum_next;
        flag_reg <= flag_next; rsp_reg <= rsp_next;
    end

    // count never exceeds depth
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CW'(STACK_DEPTH))
        else $error("count above depth");

    // a waiting result stays valid and stable until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped");

    // divider only runs during average
    a_div: assert property (@(posedge clk) disable iff (!rst_n)
        dsts.busy |-> state_reg == S_DIV)
        else $error("divider busy outside average");
endmodule

@@ verif/bswlo_checker.sv @@
`timescale 1ns / 1ps

module bswlo_checker #(
    parameter int DEPTH = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  bswlo_pkg::req_t   in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  bswlo_pkg::rsp_t   out_data,
    output int                fail_count,
    output int                pending
);
    import bswlo_pkg::*;

    logic signed [31:0] stk [DEPTH];
    int unsigned        depth_now;
    rsp_t               answers [$];

    // stack model, one answer per request
    function automatic rsp_t stack_answer(req_t r);
        rsp_t                a;
        logic signed [31:0]  t;
        logic signed [63:0]  sum;
        int unsigned         n, at, kept;
        bit                  seen;
        a = '0;
        n = depth_now;
        a.status = ST_OK;
        if (r.req_type == REQ_PUSH) begin
            if (n >= DEPTH) a.status = ST_FULL;
            else begin
                stk[n] = r.push_value;
                n++;
            end
        end else if (r.req_type <= REQ_DEDUPE && n == 0) begin
            a.status = ST_EMPTY;
        end else begin
            case (r.req_type)
                REQ_POP: n--;
                REQ_TOP: a.result_value = stk[n-1];
                REQ_SORT:
                    for (int i = 0; i < n; i++)
                        for (int j = i + 1; j < n; j++)
                            if (stk[i] > stk[j]) begin
                                t = stk[i]; stk[i] = stk[j]; stk[j] = t;
                            end
                REQ_REVERSE:
                    for (int i = 0; i < n / 2; i++) begin
                        t = stk[i]; stk[i] = stk[n-1-i]; stk[n-1-i] = t;
                    end
                REQ_MAX, REQ_RMLARGE: begin
                    at = 0;
                    for (int i = 1; i < n; i++)
                        if (stk[i] > stk[at]) at = i;
                    a.result_value = stk[at];
                    if (r.req_type == REQ_RMLARGE) begin
                        for (int i = at; i + 1 < n; i++) stk[i] = stk[i+1];
                        n--;
                    end
                end
                REQ_MIN: begin
                    a.result_value = stk[0];
                    for (int i = 1; i < n; i++)
                        if (stk[i] < a.result_value) a.result_value = stk[i];
                end
                REQ_AVG: begin
                    sum = 0;
                    for (int i = 0; i < n; i++) sum += 64'(stk[i]);
                    a.result_value = 32'(sum / $signed(64'(n)));
                end
                REQ_DEDUPE: begin
                    kept = 0;
                    for (int i = 0; i < n; i++) begin
                        seen = 0;
                        for (int j = 0; j < kept; j++)
                            if (stk[j] == stk[i]) seen = 1;
                        if (!seen) begin
                            stk[kept] = stk[i];
                            kept++;
                        end
                    end
                    n = kept;
                end
                default: ;
            endcase
        end
        depth_now = n;
        a.entry_count = 4'(n);
        a.is_empty = (n == 0);
        a.is_full = (n == DEPTH);
        return a;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        rsp_t want;
        if (!rst_n) begin
            depth_now = 0;
            answers.delete();
            fail_count = 0;
            pending = 0;
        end else begin
            if (in_valid && in_ready)
                answers.push_back(stack_answer(in_data));
            if (out_valid && out_ready) begin
                if (answers.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected word %h", out_data);
                end else begin
                    want = answers.pop_front();
                    if (want.result_value !== out_data.result_value ||
                        want.status !== out_data.status ||
                        want.entry_count !== out_data.entry_count ||
                        want.is_empty !== out_data.is_empty ||
                        want.is_full !== out_data.is_full) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: expected val=%0d st=%0d cnt=%0d e=%b f=%b,",
                                      " got val=%0d st=%0d cnt=%0d e=%b f=%b"},
                                want.result_value, want.status, want.entry_count,
                                want.is_empty, want.is_full,
                                out_data.result_value, out_data.status,
                                out_data.entry_count, out_data.is_empty,
                                out_data.is_full);
                    end
                end
            end
            pending = answers.size();
        end
    end

endmodule

@@ verif/tb_bounded_stack_with_list_ops_core.sv @@
`timescale 1ns / 1ps

module tb_bounded_stack_with_list_ops_core;
    import bswlo_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    req_t in_data = '0;
    logic out_valid;
    logic out_ready = 0;
    rsp_t out_data;
    int   fail_count;
    int   pending;

    // idle percentages per side, changed by phase
    int   send_idle_pct = 27;
    int   recv_idle_pct = 78;
    int   hold_off = 0;       // long receiver stall, in cycles
    bit   stim_done = 0;

    always #5 clk = ~clk;

    bounded_stack_with_list_ops_core #(.STACK_DEPTH(8)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    bswlo_checker #(.DEPTH(8)) chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .fail_count(fail_count), .pending(pending)
    );

    // receiver: random ready, plus a long hold-off when asked
    always @(negedge clk) begin
        if (!rst_n) out_ready <= 0;
        else if (hold_off > 0) begin
            out_ready <= 0;
            hold_off <= hold_off - 1;
        end else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // random push value, biased toward extremes and a small pool for duplicates
    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2, 3: return 32'($signed($urandom_range(6)) - 3);
            default: return $urandom;
        endcase
    endfunction

    // offer one word, hold until accepted, then maybe idle
    task automatic send_word(logic [3:0] kind, logic [31:0] val);
        in_data <= '{req_type: kind, push_value: val};
        in_valid <= 1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
    endtask

    task automatic send_random(int count);
        int k;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(99);
            // pushes are the most frequent request so the stack keeps filling; rare unused codes
            if (k < 40) send_word(REQ_PUSH, pick_value());
            else if (k < 97) send_word(4'($urandom_range(9, 1)), $urandom);
            else send_word(4'($urandom_range(15, 10)), $urandom);
        end
    endtask

    initial begin
        #10000000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int limit;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: empty cases, extremes, every request, full and ties
        for (int r = 1; r <= 9; r++) send_word(4'(r), 32'hffff_ffff);
        send_word(REQ_PUSH, 32'h8000_0000);
        send_word(REQ_PUSH, 32'h7fff_ffff);
        send_word(REQ_PUSH, 32'h7fff_ffff);
        send_word(REQ_PUSH, 32'h8000_0000);
        send_word(REQ_PUSH, 32'hffff_ffff);
        send_word(REQ_PUSH, 32'h0000_0000);
        send_word(REQ_AVG, 0);
        send_word(REQ_PUSH, 32'h7fff_ffff);
        send_word(REQ_PUSH, 32'h0000_0001);
        send_word(REQ_PUSH, 32'h1234_5678);           // full: rejected
        send_word(REQ_AVG, 0);
        send_word(REQ_MAX, 0);
        send_word(REQ_MIN, 0);
        send_word(REQ_TOP, 0);
        send_word(REQ_RMLARGE, 0);
        send_word(REQ_REVERSE, 0);
        send_word(REQ_SORT, 0);
        send_word(REQ_DEDUPE, 0);
        send_word(4'd15, 32'hffff_ffff);
        send_word(REQ_POP, 0);

        send_random(550);
        // long receiver hold-off while the sender keeps offering
        hold_off <= 300;
        send_random(20);
        send_idle_pct = 78;
        recv_idle_pct = 27;
        send_random(530);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(530);
        in_valid <= 0;

        limit = 0;
        while (pending != 0 && limit < 100000) begin
            @(posedge clk);
            limit++;
        end
        repeat (300) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/bswlo_pkg.sv
rtl/bswlo_div.sv
rtl/bounded_stack_with_list_ops_core.sv
verif/bswlo_checker.sv
verif/tb_bounded_stack_with_list_ops_core.sv
